@@ rtl/core/ndrm_pkg.sv @@
`default_nettype none
package ndrm_pkg;

    localparam int RING_ENTRIES = 64;
    localparam int QUEUE_DEPTH  = 2;

    localparam int OP_W      = 3;
    localparam int LEN_W     = 14;
    localparam int STATUS_W  = 32;
    localparam int IRQ_W     = 16;
    localparam int IDX_OUT_W = 6;
    localparam int RX_IDX_W  = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
    localparam int TX_IDX_W  = $clog2(2 * RING_ENTRIES);
    localparam int Q_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_TX_SUBMIT = 3'd0;
    localparam logic [OP_W-1:0] OP_TX_CHECK  = 3'd1;
    localparam logic [OP_W-1:0] OP_RX_CHECK  = 3'd2;
    localparam logic [OP_W-1:0] OP_IRQ       = 3'd3;
    localparam logic [OP_W-1:0] OP_LINK      = 3'd4;
    localparam logic [OP_W-1:0] OP_NOP       = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_RX_LEN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RX_BUF_SIZE = 1'd1;

    localparam logic [LEN_W-1:0] MAX_RX_LEN_RST  = 14'd1522;
    localparam logic [LEN_W-1:0] RX_BUF_SIZE_RST = 14'd4096;
    localparam logic [LEN_W-1:0] CRC_BYTES       = 14'd4;

    localparam int OWN_BIT   = 31;
    localparam int END_BIT   = 30;
    localparam int FIRST_BIT = 29;
    localparam int LAST_BIT  = 28;
    localparam int ERR_RWT   = 22;
    localparam int ERR_RES   = 21;
    localparam int ERR_RUNT  = 20;
    localparam int ERR_CRC   = 19;

    localparam logic [IRQ_W-1:0] IRQ_ABSENT  = 16'hFFFF;
    localparam logic [IRQ_W-1:0] IRQ_SYS_ERR = 16'h8000;
    localparam logic [IRQ_W-1:0] IRQ_TX_MASK = 16'h008C;
    localparam logic [IRQ_W-1:0] IRQ_RX_MASK = 16'h0053;
    localparam logic [IRQ_W-1:0] IRQ_LINKCHG = 16'h0020;

    typedef struct packed {
        logic [OP_W-1:0]  kind;
        logic [LEN_W-1:0] frame_len;
        logic             own;
        logic             rx_bad;
        logic [LEN_W-1:0] rx_len;
        logic             irq_absent;
        logic             irq_sys_err;
        logic             want_tx_reap;
        logic             want_rx;
        logic             want_link;
        logic             link_bit;
    } cmd_t;

    typedef struct packed {
        logic                 accepted;
        logic                 desc_write;
        logic                 desc_ring;
        logic [IDX_OUT_W-1:0] desc_index;
        logic [STATUS_W-1:0]  desc_word;
        logic [LEN_W-1:0]     rx_len;
        logic                 rx_dropped;
        logic                 want_tx_reap;
        logic                 want_rx;
        logic                 want_link;
        logic                 want_restart;
        logic                 can_send;
    } res_t;

endpackage
`default_nettype wire

@@ rtl/core/ndrm_front.sv @@
`default_nettype none
module ndrm_front (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_write_en,
    input  wire [ndrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [ndrm_pkg::LEN_W-1:0]     cfg_data,
    input  wire [ndrm_pkg::OP_W-1:0]      op,
    input  wire [ndrm_pkg::LEN_W-1:0]     frame_len,
    input  wire [ndrm_pkg::STATUS_W-1:0]  desc_status,
    input  wire [ndrm_pkg::IRQ_W-1:0]     irq_status,
    input  wire                           link_bit,
    output ndrm_pkg::cmd_t                cmd
);
    import ndrm_pkg::*;

    logic [LEN_W-1:0] max_rx_len_reg;
    logic [LEN_W-1:0] len;
    logic             frag_bad;
    logic             err_bad;
    logic             size_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rx_len_reg <= MAX_RX_LEN_RST;
        end
        else if (cfg_write_en && cfg_index == REG_MAX_RX_LEN)
        begin
            max_rx_len_reg <= cfg_data;
        end
    end

    assign len      = desc_status[LEN_W-1:0];
    assign frag_bad = !(desc_status[FIRST_BIT] && desc_status[LAST_BIT]);
    assign err_bad  = desc_status[ERR_RWT] || desc_status[ERR_RES]
                   || desc_status[ERR_RUNT] || desc_status[ERR_CRC];
    assign size_bad = (len < CRC_BYTES) || (len > max_rx_len_reg);

    always_comb
    begin
        case (op)
            OP_TX_SUBMIT, OP_TX_CHECK, OP_RX_CHECK, OP_IRQ, OP_LINK: cmd.kind = op;
            default: cmd.kind = OP_NOP;
        endcase
        cmd.frame_len    = frame_len;
        cmd.own          = desc_status[OWN_BIT];
        cmd.rx_bad       = frag_bad || err_bad || size_bad;
        cmd.rx_len       = len - CRC_BYTES;
        cmd.irq_absent   = (irq_status == IRQ_ABSENT);
        cmd.irq_sys_err  = |(irq_status & IRQ_SYS_ERR);
        cmd.want_tx_reap = |(irq_status & IRQ_TX_MASK);
        cmd.want_rx      = |(irq_status & IRQ_RX_MASK);
        cmd.want_link    = |(irq_status & IRQ_LINKCHG);
        cmd.link_bit     = link_bit;
    end

endmodule
`default_nettype wire

@@ rtl/core/ndrm_queue.sv @@
`default_nettype none
module ndrm_queue (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  ndrm_pkg::cmd_t push_cmd,
    output logic           not_full,
    input  wire            pop,
    output logic           not_empty,
    output ndrm_pkg::cmd_t head_cmd
);
    import ndrm_pkg::*;

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign not_full  = (count_reg != Q_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ndrm_back.sv @@
`default_nettype none
module ndrm_back (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_write_en,
    input  wire [ndrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [ndrm_pkg::LEN_W-1:0]     cfg_data,
    input  wire                           cmd_valid,
    input  ndrm_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    output logic                          res_valid,
    input  wire                           res_ready,
    output ndrm_pkg::res_t                res
);
    import ndrm_pkg::*;

    localparam int SPAN_W = TX_IDX_W + 1;
    localparam logic [SPAN_W-1:0] TX_MOD = SPAN_W'(2 * RING_ENTRIES);
    localparam logic [SPAN_W-1:0] RING_N = SPAN_W'(RING_ENTRIES);

    logic [LEN_W-1:0]    rx_buf_size_reg;
    logic [TX_IDX_W-1:0] tx_submit_reg;
    logic [TX_IDX_W-1:0] tx_submit_next;
    logic [TX_IDX_W-1:0] tx_reclaim_reg;
    logic [TX_IDX_W-1:0] tx_reclaim_next;
    logic [RX_IDX_W-1:0] rx_pos_reg;
    logic [RX_IDX_W-1:0] rx_pos_next;
    logic                link_reg;
    logic                link_next;
    logic                valid_reg;
    res_t                res_reg;
    res_t                res_next;

    logic [SPAN_W-1:0]   span_now;
    logic [SPAN_W-1:0]   span_after;
    logic [RX_IDX_W-1:0] sub_entry;
    logic [RX_IDX_W-1:0] rec_entry;

    function automatic logic [SPAN_W-1:0] tx_span(input logic [TX_IDX_W-1:0] s,
                                                   input logic [TX_IDX_W-1:0] r);
        logic [SPAN_W-1:0] d;
        d = {1'b0, s} + TX_MOD - {1'b0, r};
        tx_span = (d >= TX_MOD) ? d - TX_MOD : d;
    endfunction

    function automatic logic [TX_IDX_W-1:0] tx_inc(input logic [TX_IDX_W-1:0] v);
        tx_inc = ({1'b0, v} + 1'b1 >= TX_MOD) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [RX_IDX_W-1:0] tx_entry(input logic [TX_IDX_W-1:0] v);
        logic [SPAN_W-1:0] w;
        w = {1'b0, v};
        tx_entry = (w >= RING_N) ? RX_IDX_W'(w - RING_N) : RX_IDX_W'(w);
    endfunction

    function automatic logic end_mark(input logic [RX_IDX_W-1:0] e);
        end_mark = ({1'b0, e} == (RX_IDX_W + 1)'(RING_ENTRIES - 1));
    endfunction

    function automatic logic [RX_IDX_W-1:0] rx_inc(input logic [RX_IDX_W-1:0] e);
        rx_inc = ({1'b0, e} + 1'b1 == (RX_IDX_W + 1)'(RING_ENTRIES)) ? '0 : e + 1'b1;
    endfunction

    assign cmd_pop   = cmd_valid && (!valid_reg || res_ready);
    assign res_valid = valid_reg;
    assign res       = res_reg;
    assign span_now  = tx_span(tx_submit_reg, tx_reclaim_reg);
    assign sub_entry = tx_entry(tx_submit_reg);
    assign rec_entry = tx_entry(tx_reclaim_reg);

    always_comb
    begin
        res_next        = '0;
        tx_submit_next  = tx_submit_reg;
        tx_reclaim_next = tx_reclaim_reg;
        rx_pos_next     = rx_pos_reg;
        link_next       = link_reg;
        case (cmd.kind)
            OP_TX_SUBMIT:
            begin
                if (link_reg && span_now < RING_N)
                begin
                    res_next.accepted   = 1'b1;
                    res_next.desc_write = 1'b1;
                    res_next.desc_index = IDX_OUT_W'(sub_entry);
                    res_next.desc_word  = STATUS_W'(cmd.frame_len);
                    res_next.desc_word[OWN_BIT]   = 1'b1;
                    res_next.desc_word[END_BIT]   = end_mark(sub_entry);
                    res_next.desc_word[FIRST_BIT] = 1'b1;
                    res_next.desc_word[LAST_BIT]  = 1'b1;
                    tx_submit_next = tx_inc(tx_submit_reg);
                end
            end
            OP_TX_CHECK:
            begin
                if (span_now != '0 && !cmd.own)
                begin
                    res_next.accepted   = 1'b1;
                    res_next.desc_write = 1'b1;
                    res_next.desc_index = IDX_OUT_W'(rec_entry);
                    res_next.desc_word[END_BIT] = end_mark(rec_entry);
                    tx_reclaim_next = tx_inc(tx_reclaim_reg);
                end
            end
            OP_RX_CHECK:
            begin
                if (!cmd.own)
                begin
                    res_next.accepted   = !cmd.rx_bad;
                    res_next.rx_dropped = cmd.rx_bad;
                    res_next.rx_len     = cmd.rx_bad ? '0 : cmd.rx_len;
                    res_next.desc_write = 1'b1;
                    res_next.desc_ring  = 1'b1;
                    res_next.desc_index = IDX_OUT_W'(rx_pos_reg);
                    res_next.desc_word  = STATUS_W'(rx_buf_size_reg);
                    res_next.desc_word[OWN_BIT] = 1'b1;
                    res_next.desc_word[END_BIT] = end_mark(rx_pos_reg);
                    rx_pos_next = rx_inc(rx_pos_reg);
                end
            end
            OP_IRQ:
            begin
                if (!cmd.irq_absent)
                begin
                    if (cmd.irq_sys_err)
                    begin
                        tx_submit_next        = '0;
                        tx_reclaim_next       = '0;
                        rx_pos_next           = '0;
                        res_next.want_restart = 1'b1;
                    end
                    else
                    begin
                        res_next.want_tx_reap = cmd.want_tx_reap;
                        res_next.want_rx      = cmd.want_rx;
                        res_next.want_link    = cmd.want_link;
                    end
                end
            end
            OP_LINK:
            begin
                res_next.accepted = (cmd.link_bit != link_reg);
                link_next         = cmd.link_bit;
            end
            default:
            begin
            end
        endcase
        span_after        = tx_span(tx_submit_next, tx_reclaim_next);
        res_next.can_send = link_next && (span_after < RING_N);
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_buf_size_reg <= RX_BUF_SIZE_RST;
            tx_submit_reg   <= '0;
            tx_reclaim_reg  <= '0;
            rx_pos_reg      <= '0;
            link_reg        <= 1'b0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_en && cfg_index == REG_RX_BUF_SIZE)
            begin
                rx_buf_size_reg <= cfg_data;
            end
            if (cmd_pop)
            begin
                tx_submit_reg  <= tx_submit_next;
                tx_reclaim_reg <= tx_reclaim_next;
                rx_pos_reg     <= rx_pos_next;
                link_reg       <= link_next;
                valid_reg      <= 1'b1;
            end
            else if (res_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/nic_descriptor_ring_manager_top.sv @@
`default_nettype none
// Descriptor ring bookkeeping for a NIC driver: 64-entry transmit ring (submit
// and reclaim indices) and receive ring (one position), plus the link flag.
// Every accepted item gives exactly one result item, in order. Items are
// decoded on entry, held in a two-entry command queue and executed by the
// back end, which updates the ring state and loads the output register in the
// same cycle. Sustained rate is one item per cycle while out_ready is high.
// After reset max_rx_len is 1522 and rx_buffer_size is 4096; both may be
// rewritten only while the block is idle.
module nic_descriptor_ring_manager_top (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_write_en,
    input  wire [ndrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [ndrm_pkg::LEN_W-1:0]      cfg_data,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire [ndrm_pkg::OP_W-1:0]       op,
    input  wire [ndrm_pkg::LEN_W-1:0]      frame_len,
    input  wire [ndrm_pkg::STATUS_W-1:0]   desc_status,
    input  wire [ndrm_pkg::IRQ_W-1:0]      irq_status,
    input  wire                            link_bit,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic                           accepted,
    output logic                           desc_write,
    output logic                           desc_ring,
    output logic [ndrm_pkg::IDX_OUT_W-1:0] desc_index,
    output logic [ndrm_pkg::STATUS_W-1:0]  desc_word,
    output logic [ndrm_pkg::LEN_W-1:0]     rx_len,
    output logic                           rx_dropped,
    output logic                           want_tx_reap,
    output logic                           want_rx,
    output logic                           want_link,
    output logic                           want_restart,
    output logic                           can_send
);
    import ndrm_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    res_t res;
    logic q_not_empty;
    logic q_pop;

    ndrm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .frame_len    (frame_len),
        .desc_status  (desc_status),
        .irq_status   (irq_status),
        .link_bit     (link_bit),
        .cmd          (front_cmd)
    );

    ndrm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_cmd  (front_cmd),
        .not_full  (in_ready),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    ndrm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_valid    (q_not_empty),
        .cmd          (head_cmd),
        .cmd_pop      (q_pop),
        .res_valid    (out_valid),
        .res_ready    (out_ready),
        .res          (res)
    );

    assign accepted     = res.accepted;
    assign desc_write   = res.desc_write;
    assign desc_ring    = res.desc_ring;
    assign desc_index   = res.desc_index;
    assign desc_word    = res.desc_word;
    assign rx_len       = res.rx_len;
    assign rx_dropped   = res.rx_dropped;
    assign want_tx_reap = res.want_tx_reap;
    assign want_rx      = res.want_rx;
    assign want_link    = res.want_link;
    assign want_restart = res.want_restart;
    assign can_send     = res.can_send;

endmodule
`default_nettype wire

@@ sim/ndrm_checker.sv @@
`default_nettype none
module ndrm_checker
    import ndrm_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_write_en,
    input  wire [CFG_IDX_W-1:0] cfg_index,
    input  wire [LEN_W-1:0]     cfg_data,
    input  wire                 in_valid,
    input  wire                 in_ready,
    input  wire [OP_W-1:0]      op,
    input  wire [LEN_W-1:0]     frame_len,
    input  wire [STATUS_W-1:0]  desc_status,
    input  wire [IRQ_W-1:0]     irq_status,
    input  wire                 link_bit,
    input  wire                 out_valid,
    input  wire                 out_ready,
    input  wire                 accepted,
    input  wire                 desc_write,
    input  wire                 desc_ring,
    input  wire [IDX_OUT_W-1:0] desc_index,
    input  wire [STATUS_W-1:0]  desc_word,
    input  wire [LEN_W-1:0]     rx_len,
    input  wire                 rx_dropped,
    input  wire                 want_tx_reap,
    input  wire                 want_rx,
    input  wire                 want_link,
    input  wire                 want_restart,
    input  wire                 can_send,
    output int                  fail_count,
    output int                  outstanding
);

    logic [TX_IDX_W-1:0] tx_head;
    logic [TX_IDX_W-1:0] tx_tail;
    logic [RX_IDX_W-1:0] rx_pos;
    logic                link_now;
    logic [LEN_W-1:0]    max_len;
    logic [LEN_W-1:0]    buf_size;

    res_t ring_results_q[$];

    function automatic logic [TX_IDX_W-1:0] tx_in_flight();
        return tx_head - tx_tail;
    endfunction

    function automatic logic ring_open();
        return link_now && (tx_in_flight() < RING_ENTRIES);
    endfunction

    function automatic res_t ring_step(input logic [OP_W-1:0] kind,
                                       input logic [LEN_W-1:0] flen,
                                       input logic [STATUS_W-1:0] st,
                                       input logic [IRQ_W-1:0] irq,
                                       input logic lb);
        res_t r;
        logic [IDX_OUT_W-1:0] slot;
        logic [LEN_W-1:0] len;
        logic bad;
        r = '0;
        case (kind)
            OP_TX_SUBMIT:
            begin
                if (ring_open())
                begin
                    slot = tx_head[IDX_OUT_W-1:0];
                    r.accepted = 1'b1;
                    r.desc_write = 1'b1;
                    r.desc_index = slot;
                    r.desc_word = STATUS_W'(flen);
                    r.desc_word[FIRST_BIT] = 1'b1;
                    r.desc_word[LAST_BIT] = 1'b1;
                    r.desc_word[OWN_BIT] = 1'b1;
                    r.desc_word[END_BIT] = (slot == RING_ENTRIES - 1);
                    tx_head = tx_head + 1'b1;
                end
            end
            OP_TX_CHECK:
            begin
                if (tx_in_flight() != 0 && !st[OWN_BIT])
                begin
                    slot = tx_tail[IDX_OUT_W-1:0];
                    r.accepted = 1'b1;
                    r.desc_write = 1'b1;
                    r.desc_index = slot;
                    r.desc_word[END_BIT] = (slot == RING_ENTRIES - 1);
                    tx_tail = tx_tail + 1'b1;
                end
            end
            OP_RX_CHECK:
            begin
                if (!st[OWN_BIT])
                begin
                    slot = IDX_OUT_W'(rx_pos);
                    len = st[LEN_W-1:0];
                    bad = !(st[FIRST_BIT] && st[LAST_BIT])
                        || st[ERR_RWT] || st[ERR_RES] || st[ERR_RUNT] || st[ERR_CRC]
                        || len < CRC_BYTES || len > max_len;
                    if (bad)
                        r.rx_dropped = 1'b1;
                    else
                    begin
                        r.accepted = 1'b1;
                        r.rx_len = len - CRC_BYTES;
                    end
                    r.desc_write = 1'b1;
                    r.desc_ring = 1'b1;
                    r.desc_index = slot;
                    r.desc_word = STATUS_W'(buf_size);
                    r.desc_word[OWN_BIT] = 1'b1;
                    r.desc_word[END_BIT] = (slot == RING_ENTRIES - 1);
                    rx_pos = rx_pos + 1'b1;
                end
            end
            OP_IRQ:
            begin
                if (irq != IRQ_ABSENT)
                begin
                    if ((irq & IRQ_SYS_ERR) != 0)
                    begin
                        tx_head = '0;
                        tx_tail = '0;
                        rx_pos = '0;
                        r.want_restart = 1'b1;
                    end
                    else
                    begin
                        r.want_tx_reap = (irq & IRQ_TX_MASK) != 0;
                        r.want_rx = (irq & IRQ_RX_MASK) != 0;
                        r.want_link = (irq & IRQ_LINKCHG) != 0;
                    end
                end
            end
            OP_LINK:
            begin
                r.accepted = (lb != link_now);
                link_now = lb;
            end
            default:
            begin
            end
        endcase
        r.can_send = ring_open();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [STATUS_W-1:0] want,
                               input logic [STATUS_W-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("ndrm_checker: %s expected %h got %h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            tx_head = '0;
            tx_tail = '0;
            rx_pos = '0;
            link_now = 1'b0;
            max_len = MAX_RX_LEN_RST;
            buf_size = RX_BUF_SIZE_RST;
            ring_results_q.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == REG_MAX_RX_LEN)
                    max_len = cfg_data;
                else if (cfg_index == REG_RX_BUF_SIZE)
                    buf_size = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                got = {accepted, desc_write, desc_ring, desc_index, desc_word, rx_len,
                       rx_dropped, want_tx_reap, want_rx, want_link, want_restart, can_send};
                if (ring_results_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ndrm_checker: unexpected result item %h", got);
                end
                else
                begin
                    want = ring_results_q.pop_front();
                    check_field("accepted", STATUS_W'(want.accepted), STATUS_W'(got.accepted));
                    check_field("desc_write", STATUS_W'(want.desc_write),
                                STATUS_W'(got.desc_write));
                    check_field("desc_ring", STATUS_W'(want.desc_ring), STATUS_W'(got.desc_ring));
                    check_field("desc_index", STATUS_W'(want.desc_index),
                                STATUS_W'(got.desc_index));
                    check_field("desc_word", want.desc_word, got.desc_word);
                    check_field("rx_len", STATUS_W'(want.rx_len), STATUS_W'(got.rx_len));
                    check_field("rx_dropped", STATUS_W'(want.rx_dropped),
                                STATUS_W'(got.rx_dropped));
                    check_field("want_tx_reap", STATUS_W'(want.want_tx_reap),
                                STATUS_W'(got.want_tx_reap));
                    check_field("want_rx", STATUS_W'(want.want_rx), STATUS_W'(got.want_rx));
                    check_field("want_link", STATUS_W'(want.want_link), STATUS_W'(got.want_link));
                    check_field("want_restart", STATUS_W'(want.want_restart),
                                STATUS_W'(got.want_restart));
                    check_field("can_send", STATUS_W'(want.can_send), STATUS_W'(got.can_send));
                end
            end
            if (in_valid && in_ready)
                ring_results_q.push_back(ring_step(op, frame_len, desc_status, irq_status,
                                                   link_bit));
            outstanding <= ring_results_q.size();
        end
    end

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none
module tb
    import ndrm_pkg::*;
();

    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 70;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [OP_W-1:0]      op;
    logic [LEN_W-1:0]     frame_len;
    logic [STATUS_W-1:0]  desc_status;
    logic [IRQ_W-1:0]     irq_status;
    logic                 link_bit;
    logic                 out_valid;
    logic                 out_ready;
    logic                 accepted;
    logic                 desc_write;
    logic                 desc_ring;
    logic [IDX_OUT_W-1:0] desc_index;
    logic [STATUS_W-1:0]  desc_word;
    logic [LEN_W-1:0]     rx_len;
    logic                 rx_dropped;
    logic                 want_tx_reap;
    logic                 want_rx;
    logic                 want_link;
    logic                 want_restart;
    logic                 can_send;

    int   fail_count;
    int   outstanding;
    logic no_idle;
    logic hold_go;
    int   cur_max_len;

    nic_descriptor_ring_manager_top DUT (.*);

    ndrm_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin : receiver
        logic hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= no_idle || ($urandom_range(99) >= 31);
        end
    end

    task automatic push_item(input logic [OP_W-1:0] o, input logic [LEN_W-1:0] fl,
                             input logic [STATUS_W-1:0] st, input logic [IRQ_W-1:0] irq,
                             input logic lb);
        if (!no_idle && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 31);
        end
        in_valid <= 1'b1;
        op <= o;
        frame_len <= fl;
        desc_status <= st;
        irq_status <= irq;
        link_bit <= lb;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_MAX_RX_LEN)
            cur_max_len = int'(val);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [STATUS_W-1:0] rx_word(input logic own, input logic first,
                                                   input logic last, input logic [3:0] errs,
                                                   input logic [LEN_W-1:0] len);
        logic [STATUS_W-1:0] w;
        w = STATUS_W'(len);
        w[OWN_BIT] = own;
        w[FIRST_BIT] = first;
        w[LAST_BIT] = last;
        w[ERR_RWT] = errs[3];
        w[ERR_RES] = errs[2];
        w[ERR_RUNT] = errs[1];
        w[ERR_CRC] = errs[0];
        return w;
    endfunction

    task automatic random_item();
        int pick;
        int v;
        logic [OP_W-1:0] o;
        logic [LEN_W-1:0] fl;
        logic [LEN_W-1:0] len;
        logic [STATUS_W-1:0] st;
        logic [IRQ_W-1:0] irq;
        logic lb;
        pick = $urandom_range(99);
        fl = LEN_W'($urandom_range(16383));
        st = $urandom();
        irq = IRQ_W'($urandom_range(65535)) & ~IRQ_SYS_ERR;
        lb = 1'($urandom_range(1));
        if (pick < 28)
            o = OP_TX_SUBMIT;
        else if (pick < 46)
        begin
            o = OP_TX_CHECK;
            st[OWN_BIT] = ($urandom_range(3) == 0);
        end
        else if (pick < 72)
        begin
            o = OP_RX_CHECK;
            st[OWN_BIT] = ($urandom_range(99) < 15);
            if ($urandom_range(99) < 85)
            begin
                st[FIRST_BIT] = 1'b1;
                st[LAST_BIT] = 1'b1;
            end
            if ($urandom_range(99) < 85)
            begin
                st[ERR_RWT] = 1'b0;
                st[ERR_RES] = 1'b0;
                st[ERR_RUNT] = 1'b0;
                st[ERR_CRC] = 1'b0;
            end
            case ($urandom_range(3))
                0: len = LEN_W'($urandom_range(16383));
                1: len = LEN_W'($urandom_range(8));
                2:
                begin
                    v = cur_max_len + $urandom_range(4) - 2;
                    if (v > 16383)
                        v = 16383;
                    len = LEN_W'(v);
                end
                default: len = LEN_W'($urandom_range(cur_max_len, 4));
            endcase
            st[LEN_W-1:0] = len;
        end
        else if (pick < 82)
        begin
            o = OP_IRQ;
            v = $urandom_range(19);
            if (v == 0)
                irq = IRQ_ABSENT;
            else if (v == 1)
                irq = irq | IRQ_SYS_ERR;
        end
        else if (pick < 94)
        begin
            o = OP_LINK;
            lb = ($urandom_range(4) != 0);
        end
        else
            o = OP_W'($urandom_range(OP_NOP, OP_LINK + 1));
        push_item(o, fl, st, irq, lb);
    endtask

    initial
    begin : stimulus
        logic [STATUS_W-1:0] st;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = REG_MAX_RX_LEN;
        cfg_data = '0;
        in_valid = 1'b0;
        op = OP_NOP;
        frame_len = '0;
        desc_status = '0;
        irq_status = '0;
        link_bit = 1'b0;
        no_idle = 1'b0;
        hold_go = 1'b0;
        cur_max_len = int'(MAX_RX_LEN_RST);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings
        push_item(OP_TX_SUBMIT, 14'h3FFF, '0, '0, 1'b0);
        push_item(OP_TX_CHECK, '0, '0, '0, 1'b0);
        push_item(OP_LINK, '0, '0, '0, 1'b1);
        push_item(OP_LINK, '0, '0, '0, 1'b1);
        push_item(OP_TX_SUBMIT, 14'h0000, '0, '0, 1'b0);
        push_item(OP_TX_SUBMIT, 14'h3FFF, '0, '0, 1'b0);
        push_item(OP_TX_CHECK, '0, 32'hFFFF_FFFF, '0, 1'b0);
        push_item(OP_TX_CHECK, '0, 32'h7FFF_FFFF, '0, 1'b0);
        push_item(OP_RX_CHECK, '0, rx_word(1'b1, 1'b1, 1'b1, 4'b0000, 14'd100), '0, 1'b0);
        push_item(OP_RX_CHECK, '0, rx_word(1'b0, 1'b1, 1'b1, 4'b0000, 14'd4), '0, 1'b0);
        push_item(OP_RX_CHECK, '0, rx_word(1'b0, 1'b1, 1'b1, 4'b0000, 14'd1522), '0, 1'b0);
        push_item(OP_RX_CHECK, '0, rx_word(1'b0, 1'b1, 1'b1, 4'b0000, 14'd1523), '0, 1'b0);
        push_item(OP_RX_CHECK, '0, rx_word(1'b0, 1'b1, 1'b1, 4'b0000, 14'd3), '0, 1'b0);
        push_item(OP_RX_CHECK, '0, rx_word(1'b0, 1'b0, 1'b1, 4'b0000, 14'd64), '0, 1'b0);
        push_item(OP_RX_CHECK, '0, rx_word(1'b0, 1'b1, 1'b0, 4'b0000, 14'd64), '0, 1'b0);
        push_item(OP_RX_CHECK, '0, rx_word(1'b0, 1'b1, 1'b1, 4'b1000, 14'd64), '0, 1'b0);
        push_item(OP_RX_CHECK, '0, rx_word(1'b0, 1'b1, 1'b1, 4'b0100, 14'd64), '0, 1'b0);
        push_item(OP_RX_CHECK, '0, rx_word(1'b0, 1'b1, 1'b1, 4'b0010, 14'd64), '0, 1'b0);
        push_item(OP_RX_CHECK, '0, rx_word(1'b0, 1'b1, 1'b1, 4'b0001, 14'd64), '0, 1'b0);
        push_item(OP_IRQ, '0, '0, IRQ_ABSENT, 1'b0);
        push_item(OP_IRQ, '0, '0, IRQ_TX_MASK | IRQ_RX_MASK | IRQ_LINKCHG, 1'b0);
        push_item(OP_IRQ, '0, '0, IRQ_SYS_ERR, 1'b0);
        push_item(OP_LINK + 3'd1, 14'h3FFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        push_item(OP_NOP, 14'h3FFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        push_item(OP_LINK, '0, '0, '0, 1'b0);
        wait_drained();

        // low extremes
        write_reg(REG_MAX_RX_LEN, 14'd4);
        write_reg(REG_RX_BUF_SIZE, 14'd0);
        repeat (PHASE_ITEMS) random_item();
        wait_drained();

        // high extremes, back-to-back traffic
        write_reg(REG_MAX_RX_LEN, 14'h3FFF);
        write_reg(REG_RX_BUF_SIZE, 14'h3FFF);
        no_idle <= 1'b1;
        repeat (PHASE_ITEMS) random_item();
        wait_drained();
        no_idle <= 1'b0;

        // hold the result side off for a while, fill the tx ring, then reclaim it
        write_reg(REG_MAX_RX_LEN, LEN_W'($urandom_range(16383, 4)));
        write_reg(REG_RX_BUF_SIZE, LEN_W'($urandom_range(16383)));
        push_item(OP_LINK, '0, '0, '0, 1'b1);
        hold_go <= 1'b1;
        repeat (75)
            push_item(OP_TX_SUBMIT, LEN_W'($urandom_range(16383)), $urandom(),
                      IRQ_W'($urandom_range(65535)), 1'($urandom_range(1)));
        repeat (70)
        begin
            st = $urandom();
            st[OWN_BIT] = 1'b0;
            push_item(OP_TX_CHECK, LEN_W'($urandom_range(16383)), st,
                      IRQ_W'($urandom_range(65535)), 1'($urandom_range(1)));
        end
        repeat (PHASE_ITEMS) random_item();
        wait_drained();

        write_reg(REG_MAX_RX_LEN, MAX_RX_LEN_RST);
        write_reg(REG_RX_BUF_SIZE, RX_BUF_SIZE_RST);
        repeat (PHASE_ITEMS) random_item();
        wait_drained();

        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
rtl/core/ndrm_pkg.sv
rtl/core/ndrm_front.sv
rtl/core/ndrm_queue.sv
rtl/core/ndrm_back.sv
rtl/core/nic_descriptor_ring_manager_top.sv
sim/ndrm_checker.sv
sim/tb.sv
